// ----- sv/tdr_pkg.sv -----
package tdr_pkg;

    localparam int SCREEN_W = 64;
    localparam int SCREEN_H = 64;
    localparam int XW = $clog2(SCREEN_W);
    localparam int YW = $clog2(SCREEN_H);
    localparam int AW = XW + YW;
    localparam int DEPTH_N = SCREEN_W * SCREEN_H;
    localparam int NUM_W = 48;
    localparam int DEN_W = 24;
    localparam int CNT_W = $clog2(NUM_W + 1);

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_SCAN  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;
    localparam logic signed [15:0] DEPTH_MAX = 16'sh7fff;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WEIGHT,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_READ,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

// ----- sv/tdr_divider.sv -----
module tdr_divider
    import tdr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [NUM_W-1:0]  num,
    input  logic signed [DEN_W-1:0]  den,
    output div_ctl_t                 ctl,
    output logic signed [NUM_W-1:0]  quot
);
    // restoring divider on magnitudes, one quotient bit a cycle
    logic [NUM_W-1:0] q_reg, q_next;
    logic [NUM_W:0]   r_reg, r_next;
    logic [NUM_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [NUM_W:0]   trial;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;

    always_comb
    begin
        num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[NUM_W-1:0], q_reg[NUM_W-1]};
        if (start)
        begin
            q_next = num_mag;
            r_next = '0;
            d_next = NUM_W'(den_mag);
            cnt_next = CNT_W'(NUM_W);
            neg_next = num[NUM_W-1] ^ den[DEN_W-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign quot = neg_reg ? NUM_W'(-q_reg) : NUM_W'(q_reg);
    assign ctl = '{start: start, busy: busy_reg, done: done_reg};
endmodule

// ----- sv/triangle_depth_rasterizer_top.sv -----
// Barycentric triangle rasterizer with a 64x64 depth store. A load transfer
// latches three vertices, computes the doubled signed area and a bounding box
// clipped to the screen, and gives no result; the block is ready again on the
// next cycle. A scan transfer visits the next box pixel (x outer, y inner) and
// always gives one result. An inside pixel walks three shared 24x16 multiplies
// and a 48-step restoring divider via WEIGHT, READ, MUL0 to MUL2, DIV, CMP, OUT;
// an outside pixel via WEIGHT, READ and OUT, a zero-area triangle's pixel via
// WEIGHT and OUT, and a scan with nothing left straight from IDLE. A clear
// transfer sweeps all 4096 depth entries one entry a cycle and gives no
// result; the same sweep runs after reset, when no input is taken.
// A pending result sits in an output register; in_ready is low while busy.
module triangle_depth_rasterizer_top
    import tdr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [9:0]  vert0_x,
    input  logic signed [9:0]  vert0_y,
    input  logic signed [15:0] vert0_depth,
    input  logic signed [9:0]  vert1_x,
    input  logic signed [9:0]  vert1_y,
    input  logic signed [15:0] vert1_depth,
    input  logic signed [9:0]  vert2_x,
    input  logic signed [9:0]  vert2_y,
    input  logic signed [15:0] vert2_depth,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               frag_valid,
    output logic [5:0]         pix_x,
    output logic [5:0]         pix_y,
    output logic signed [15:0] frag_depth,
    output logic [7:0]         frag_shade,
    output logic               scan_last
);
    state_t state_reg, state_next;

    logic [7:0] shade_reg;
    logic signed [9:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [15:0] az_reg, bz_reg, cz_reg;
    logic signed [DEN_W-1:0] area_reg;
    logic [XW-1:0] xmin_reg, xmax_reg, sx_reg;
    logic [YW-1:0] ymin_reg, ymax_reg, sy_reg;
    logic active_reg;
    logic [AW:0] clr_reg;
    logic signed [DEN_W-1:0] wa_reg, wb_reg, wg_reg;
    logic signed [NUM_W-1:0] acc_reg;
    logic signed [15:0] z_reg;
    logic signed [15:0] rd_reg;
    logic signed [15:0] mem [DEPTH_N];

    logic ov_reg, fv_reg, last_reg;
    logic [5:0] px_reg, py_reg;
    logic signed [15:0] fd_reg;
    logic [7:0] fs_reg;

    logic in_xfer;
    logic div_start;
    div_ctl_t div_ctl;
    logic signed [NUM_W-1:0] quot;
    logic signed [NUM_W-1:0] acc_sum;

    assign in_xfer = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE) && !ov_reg;

    // the divider takes the full sum, third product included
    tdr_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(acc_sum), .den(area_reg), .ctl(div_ctl), .quot(quot)
    );

    // setup arithmetic for a load
    logic signed [10:0] l_bc_y, l_ac_x, l_cb_x, l_ac_y;
    logic signed [DEN_W-1:0] l_area;
    logic signed [9:0] l_minx, l_miny, l_maxx, l_maxy;
    always_comb
    begin
        l_bc_y = 11'(vert1_y) - 11'(vert2_y);
        l_ac_x = 11'(vert0_x) - 11'(vert2_x);
        l_cb_x = 11'(vert2_x) - 11'(vert1_x);
        l_ac_y = 11'(vert0_y) - 11'(vert2_y);
        l_area = DEN_W'(l_bc_y * l_ac_x) + DEN_W'(l_cb_x * l_ac_y);
        l_minx = vert0_x;
        if (vert1_x < l_minx) l_minx = vert1_x;
        if (vert2_x < l_minx) l_minx = vert2_x;
        l_miny = vert0_y;
        if (vert1_y < l_miny) l_miny = vert1_y;
        if (vert2_y < l_miny) l_miny = vert2_y;
        l_maxx = vert0_x;
        if (vert1_x > l_maxx) l_maxx = vert1_x;
        if (vert2_x > l_maxx) l_maxx = vert2_x;
        l_maxy = vert0_y;
        if (vert1_y > l_maxy) l_maxy = vert1_y;
        if (vert2_y > l_maxy) l_maxy = vert2_y;
    end

    function automatic logic [5:0] clip6(input logic signed [9:0] v, input int hi);
        logic [5:0] r;
        if (v < 0) r = '0;
        else if (v > 10'(hi)) r = 6'(hi);
        else r = 6'(v);
        return r;
    endfunction

    // weights at the current pixel
    logic signed [10:0] w_px, w_py;
    logic signed [DEN_W-1:0] w_a, w_b;
    logic in_tri;
    always_comb
    begin
        w_px = 11'($signed({1'b0, sx_reg})) - 11'(cx_reg);
        w_py = 11'($signed({1'b0, sy_reg})) - 11'(cy_reg);
        w_a = DEN_W'((11'(by_reg) - 11'(cy_reg)) * w_px)
            + DEN_W'((11'(cx_reg) - 11'(bx_reg)) * w_py);
        w_b = DEN_W'((11'(cy_reg) - 11'(ay_reg)) * w_px)
            + DEN_W'((11'(ax_reg) - 11'(cx_reg)) * w_py);
        if (area_reg > 0)
            in_tri = !wa_reg[DEN_W-1] && !wb_reg[DEN_W-1] && !wg_reg[DEN_W-1];
        else
            in_tri = (wa_reg <= 0) && (wb_reg <= 0) && (wg_reg <= 0);
    end

    // one shared multiplier for the three depth products
    logic signed [DEN_W-1:0] m_a;
    logic signed [15:0] m_b;
    logic signed [NUM_W-1:0] m_p;
    always_comb
    begin
        unique case (state_reg)
            ST_MUL0: begin m_a = wa_reg; m_b = az_reg; end
            ST_MUL1: begin m_a = wb_reg; m_b = bz_reg; end
            default: begin m_a = wg_reg; m_b = cz_reg; end
        endcase
        m_p = NUM_W'(m_a * m_b);
        acc_sum = acc_reg + m_p;
    end

    logic [AW-1:0] pix_addr;
    assign pix_addr = {sy_reg, sx_reg};
    logic last_pix;
    assign last_pix = (sy_reg == ymax_reg) && (sx_reg == xmax_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_xfer)
                begin
                    priority if (req_type == REQ_CLEAR) state_next = ST_CLEAR;
                    else if (req_type == REQ_SCAN && active_reg)
                        state_next = ST_WEIGHT;
                    else state_next = ST_IDLE;
                end
            ST_CLEAR: if (clr_reg == (AW+1)'(DEPTH_N - 1)) state_next = ST_IDLE;
            ST_WEIGHT: state_next = (area_reg != 0) ? ST_READ : ST_OUT;
            ST_READ: state_next = in_tri ? ST_MUL0 : ST_OUT;
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DIV;
            ST_DIV: if (div_ctl.done) state_next = ST_CMP;
            ST_CMP: state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        div_start = (state_reg == ST_MUL2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            shade_reg <= 8'd255;
            active_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) shade_reg <= cfg_wdata;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            else clr_reg <= '0;
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            if (in_xfer && req_type == REQ_LOAD) active_reg <= 1'b1;
            if (in_xfer && req_type == REQ_SCAN && !active_reg) ov_reg <= 1'b1;
            if (state_reg == ST_OUT)
            begin
                ov_reg <= 1'b1;
                if (last_pix) active_reg <= 1'b0;
            end
        end
    end

    // depth memory: one write port, one registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR) mem[clr_reg[AW-1:0]] <= DEPTH_MIN;
        else if (state_reg == ST_CMP && z_reg > rd_reg) mem[pix_addr] <= z_reg;
        rd_reg <= mem[pix_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && req_type == REQ_LOAD)
        begin
            ax_reg <= vert0_x; ay_reg <= vert0_y; az_reg <= vert0_depth;
            bx_reg <= vert1_x; by_reg <= vert1_y; bz_reg <= vert1_depth;
            cx_reg <= vert2_x; cy_reg <= vert2_y; cz_reg <= vert2_depth;
            area_reg <= l_area;
            xmin_reg <= clip6(l_minx, SCREEN_W - 1);
            ymin_reg <= clip6(l_miny, SCREEN_H - 1);
            xmax_reg <= clip6(l_maxx, SCREEN_W - 1);
            ymax_reg <= clip6(l_maxy, SCREEN_H - 1);
            sx_reg <= clip6(l_minx, SCREEN_W - 1);
            sy_reg <= clip6(l_miny, SCREEN_H - 1);
        end
        if (in_xfer && req_type == REQ_SCAN && !active_reg)
        begin
            fv_reg <= 1'b0; px_reg <= '0; py_reg <= '0;
            fd_reg <= '0; fs_reg <= '0; last_reg <= 1'b1;
        end
        if (state_reg == ST_WEIGHT)
        begin
            wa_reg <= w_a;
            wb_reg <= w_b;
            wg_reg <= area_reg - w_a - w_b;
            fv_reg <= 1'b0;
        end
        unique case (state_reg)
            ST_MUL0: acc_reg <= m_p;
            ST_MUL1, ST_MUL2: acc_reg <= acc_sum;
            default: ;
        endcase
        if (div_ctl.done)
        begin
            // saturate to the depth range
            priority if (quot > NUM_W'(DEPTH_MAX)) z_reg <= DEPTH_MAX;
            else if (quot < NUM_W'(DEPTH_MIN)) z_reg <= DEPTH_MIN;
            else z_reg <= 16'(quot);
        end
        if (state_reg == ST_CMP) fv_reg <= (z_reg > rd_reg);
        if (state_reg == ST_OUT)
        begin
            px_reg <= 6'(sx_reg);
            py_reg <= 6'(sy_reg);
            fd_reg <= fv_reg ? z_reg : 16'sd0;
            fs_reg <= fv_reg ? shade_reg : 8'd0;
            last_reg <= last_pix;
            // advance scan, y inner
            if (sy_reg < ymax_reg) sy_reg <= sy_reg + 1'b1;
            else
            begin
                sy_reg <= ymin_reg;
                if (sx_reg < xmax_reg) sx_reg <= sx_reg + 1'b1;
            end
        end
    end

    assign out_valid = ov_reg;
    assign frag_valid = fv_reg && ov_reg;
    assign pix_x = px_reg;
    assign pix_y = py_reg;
    assign frag_depth = fd_reg;
    assign frag_shade = fs_reg;
    assign scan_last = last_reg;

    a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready) else $error("ready while busy");
    a_div_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.done |-> (state_reg == ST_DIV)) else $error("stray divide done");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

// ----- sim/tb_triangle_depth_rasterizer_top.sv -----
`timescale 1ns / 100ps

module tb_triangle_depth_rasterizer_top;
    import tdr_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    // covers a full depth sweep plus the load setup
    localparam int SETTLE_CYCLES = 4200;

    typedef struct {
        logic [1:0] req;
        logic [2:0][9:0] vx;
        logic [2:0][9:0] vy;
        logic [2:0][15:0] vz;
    } raster_req_t;

    typedef struct {
        logic fv;
        logic [5:0] px;
        logic [5:0] py;
        logic signed [15:0] fz;
        logic [7:0] fs;
        logic last;
    } frag_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] req_type = REQ_SCAN;
    logic signed [9:0] vert0_x = '0, vert0_y = '0, vert1_x = '0;
    logic signed [9:0] vert1_y = '0, vert2_x = '0, vert2_y = '0;
    logic signed [15:0] vert0_depth = '0, vert1_depth = '0, vert2_depth = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic frag_valid;
    logic [5:0] pix_x, pix_y;
    logic signed [15:0] frag_depth;
    logic [7:0] frag_shade;
    logic scan_last;

    raster_req_t pending_reqs[$];
    frag_t expected_frags[$];
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit in_taken = 1'b0;
    int errors = 0;
    int cycles = 0;
    int n_results = 0;
    int n_frags = 0;
    int n_loads = 0;
    int n_clears = 0;

    // shadow copy of the block's state
    logic [7:0] shade_m = 8'd255;
    int tx_m[3], ty_m[3], tz_m[3];
    longint area_m = 0;
    int box_x0 = 0, box_y0 = 0, box_x1 = 0, box_y1 = 0;
    int scan_x_m = 0, scan_y_m = 0;
    bit scan_on = 1'b0;
    logic signed [15:0] zbuf_m[SCREEN_W * SCREEN_H];

    triangle_depth_rasterizer_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type),
        .vert0_x(vert0_x), .vert0_y(vert0_y), .vert0_depth(vert0_depth),
        .vert1_x(vert1_x), .vert1_y(vert1_y), .vert1_depth(vert1_depth),
        .vert2_x(vert2_x), .vert2_y(vert2_y), .vert2_depth(vert2_depth),
        .out_valid(out_valid), .out_ready(out_ready),
        .frag_valid(frag_valid), .pix_x(pix_x), .pix_y(pix_y),
        .frag_depth(frag_depth), .frag_shade(frag_shade), .scan_last(scan_last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Weight of the edge opposite vertex k is taken as the weight of vertex k.
    function automatic bit same_sign(longint w, longint a);
        return (a > 0) ? (w >= 0) : (w <= 0);
    endfunction

    // Advance the shadow state by one accepted transfer and queue its result.
    task automatic rasterize_req(input raster_req_t r);
        frag_t f;
        longint wa, wb, wg, z;
        int idx;
        case (r.req)
            REQ_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    tx_m[i] = $signed(r.vx[i]);
                    ty_m[i] = $signed(r.vy[i]);
                    tz_m[i] = $signed(r.vz[i]);
                end
                area_m = longint'(ty_m[1] - ty_m[2]) * (tx_m[0] - tx_m[2])
                       + longint'(tx_m[2] - tx_m[1]) * (ty_m[0] - ty_m[2]);
                box_x0 = SCREEN_W - 1; box_y0 = SCREEN_H - 1;
                box_x1 = 0; box_y1 = 0;
                for (int i = 0; i < 3; i++)
                begin
                    if (tx_m[i] < box_x0) box_x0 = tx_m[i];
                    if (ty_m[i] < box_y0) box_y0 = ty_m[i];
                    if (tx_m[i] > box_x1) box_x1 = tx_m[i];
                    if (ty_m[i] > box_y1) box_y1 = ty_m[i];
                end
                if (box_x0 < 0) box_x0 = 0;
                if (box_y0 < 0) box_y0 = 0;
                if (box_x1 > SCREEN_W - 1) box_x1 = SCREEN_W - 1;
                if (box_y1 > SCREEN_H - 1) box_y1 = SCREEN_H - 1;
                scan_x_m = box_x0;
                scan_y_m = box_y0;
                scan_on = 1'b1;
                n_loads++;
            end
            REQ_CLEAR:
            begin
                foreach (zbuf_m[i]) zbuf_m[i] = DEPTH_MIN;
                n_clears++;
            end
            REQ_SCAN:
            begin
                f = '{fv: 1'b0, px: '0, py: '0, fz: '0, fs: '0, last: 1'b1};
                if (scan_on)
                begin
                    f.px = scan_x_m[5:0];
                    f.py = scan_y_m[5:0];
                    if (area_m != 0)
                    begin
                        wa = longint'(ty_m[1] - ty_m[2]) * (scan_x_m - tx_m[2])
                           + longint'(tx_m[2] - tx_m[1]) * (scan_y_m - ty_m[2]);
                        wb = longint'(ty_m[2] - ty_m[0]) * (scan_x_m - tx_m[2])
                           + longint'(tx_m[0] - tx_m[2]) * (scan_y_m - ty_m[2]);
                        wg = area_m - wa - wb;
                        if (same_sign(wa, area_m) && same_sign(wb, area_m)
                            && same_sign(wg, area_m))
                        begin
                            z = (wa * tz_m[0] + wb * tz_m[1] + wg * tz_m[2]) / area_m;
                            if (z > 32767) z = 32767;
                            if (z < -32768) z = -32768;
                            idx = scan_x_m + SCREEN_W * scan_y_m;
                            if (z > zbuf_m[idx])
                            begin
                                zbuf_m[idx] = z[15:0];
                                f.fv = 1'b1;
                                f.fz = z[15:0];
                                f.fs = shade_m;
                            end
                        end
                    end
                    f.last = 1'b0;
                    if (scan_y_m < box_y1)
                        scan_y_m++;
                    else
                    begin
                        scan_y_m = box_y0;
                        if (scan_x_m < box_x1)
                            scan_x_m++;
                        else
                        begin
                            f.last = 1'b1;
                            scan_on = 1'b0;
                        end
                    end
                end
                expected_frags.push_back(f);
            end
            default: ;  // reserved code: drop
        endcase
    endtask

    // Monitor: sample both transfers at the rising edge.
    always @(posedge clk)
    begin
        frag_t e;
        in_taken = 1'b0;
        if (rst_n)
        begin
            cycles++;
            if (cfg_we)
                shade_m = cfg_wdata;
            if (in_valid && in_ready)
            begin
                in_taken = 1'b1;
                rasterize_req('{req: req_type,
                    vx: {vert2_x, vert1_x, vert0_x},
                    vy: {vert2_y, vert1_y, vert0_y},
                    vz: {vert2_depth, vert1_depth, vert0_depth}});
            end
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_frags.size() == 0)
                begin
                    $error("unexpected result transfer at pixel (%0d,%0d)", pix_x, pix_y);
                    errors++;
                end
                else
                begin
                    e = expected_frags.pop_front();
                    if (frag_valid) n_frags++;
                    if (frag_valid !== e.fv)
                    begin
                        $error("frag_valid: expected %0d, got %0d", e.fv, frag_valid);
                        errors++;
                    end
                    if (pix_x !== e.px)
                    begin
                        $error("pix_x: expected %0d, got %0d", e.px, pix_x);
                        errors++;
                    end
                    if (pix_y !== e.py)
                    begin
                        $error("pix_y: expected %0d, got %0d", e.py, pix_y);
                        errors++;
                    end
                    if (frag_depth !== e.fz)
                    begin
                        $error("frag_depth: expected %0d, got %0d", e.fz, frag_depth);
                        errors++;
                    end
                    if (frag_shade !== e.fs)
                    begin
                        $error("frag_shade: expected %0d, got %0d", e.fs, frag_shade);
                        errors++;
                    end
                    if (scan_last !== e.last)
                    begin
                        $error("scan_last: expected %0d, got %0d", e.last, scan_last);
                        errors++;
                    end
                end
            end
            if (cycles > LIMIT_CYCLES)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Driver: change inputs at the falling edge; hold valid until the transfer.
    always @(negedge clk)
    begin
        raster_req_t r;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    r = pending_reqs.pop_front();
                    req_type <= r.req;
                    vert0_x <= r.vx[0]; vert0_y <= r.vy[0]; vert0_depth <= r.vz[0];
                    vert1_x <= r.vx[1]; vert1_y <= r.vy[1]; vert1_depth <= r.vz[1];
                    vert2_x <= r.vx[2]; vert2_y <= r.vy[2]; vert2_depth <= r.vz[2];
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic raster_req_t plain_req(logic [1:0] code);
        raster_req_t r;
        r.req = code;
        r.vx = 30'($urandom);
        r.vy = 30'($urandom);
        r.vz = 48'({$urandom, $urandom});
        return r;
    endfunction

    function automatic int box_pixels(raster_req_t r);
        int x0 = SCREEN_W - 1, y0 = SCREEN_H - 1, x1 = 0, y1 = 0;
        for (int i = 0; i < 3; i++)
        begin
            if ($signed(r.vx[i]) < x0) x0 = $signed(r.vx[i]);
            if ($signed(r.vy[i]) < y0) y0 = $signed(r.vy[i]);
            if ($signed(r.vx[i]) > x1) x1 = $signed(r.vx[i]);
            if ($signed(r.vy[i]) > y1) y1 = $signed(r.vy[i]);
        end
        x0 = (x0 < 0) ? 0 : x0;
        y0 = (y0 < 0) ? 0 : y0;
        x1 = (x1 > SCREEN_W - 1) ? SCREEN_W - 1 : x1;
        y1 = (y1 > SCREEN_H - 1) ? SCREEN_H - 1 : y1;
        return (x1 - x0 + 1) * (y1 - y0 + 1);
    endfunction

    // Queue a load and n scans; returns the number of queued transfers.
    function automatic int queue_triangle(raster_req_t ld, int n);
        pending_reqs.push_back(ld);
        repeat (n) pending_reqs.push_back(plain_req(REQ_SCAN));
        return n + 1;
    endfunction

    // Random triangle: mostly small near the screen, some degenerate or wild.
    function automatic int random_triangle();
        raster_req_t r;
        int cx, cy, sp, n, sel;
        r = plain_req(REQ_LOAD);
        sel = $urandom_range(0, 99);
        cx = $urandom_range(0, 79) - 8;
        cy = $urandom_range(0, 79) - 8;
        sp = $urandom_range(1, 9);
        for (int i = 0; i < 3; i++)
        begin
            r.vx[i] = 10'(cx + int'($urandom_range(0, 2 * sp)) - sp);
            r.vy[i] = 10'(cy + int'($urandom_range(0, 2 * sp)) - sp);
        end
        if (sel < 8)
        begin
            // collinear: zero area
            r.vx[2] = 10'(r.vx[0] + 2 * (r.vx[1] - r.vx[0]));
            r.vy[2] = 10'(r.vy[0] + 2 * (r.vy[1] - r.vy[0]));
        end
        if (sel >= 95)
        begin
            r.vx = 30'($urandom);
            r.vy = 30'($urandom);
            n = $urandom_range(1, 20);
        end
        else if (sel >= 88)
            n = $urandom_range(0, box_pixels(r));   // cut short by the next load
        else
            n = box_pixels(r) + $urandom_range(0, 2);
        return queue_triangle(r, n);
    endfunction

    task automatic wait_drained();
        wait (pending_reqs.size() == 0 && !in_valid && expected_frags.size() == 0);
    endtask

    task automatic write_shade(logic [7:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        raster_req_t r;
        int queued;
        int phase_goal;
        logic [7:0] shades[3];
        foreach (zbuf_m[i]) zbuf_m[i] = DEPTH_MIN;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: scan before any load, reserved code, full-range extremes.
        pending_reqs.push_back(plain_req(REQ_SCAN));
        pending_reqs.push_back(plain_req(2'd3));
        r = plain_req(REQ_LOAD);
        r.vx = {10'h200, 10'h1ff, 10'h200};
        r.vy = {10'h1ff, 10'h200, 10'h200};
        r.vz = {16'h8000, 16'h7fff, 16'h7fff};
        queued = queue_triangle(r, 3);   // whole-screen box, dropped by next load
        // clockwise triangle clipped at the corner, cut short by the next load
        r.vx = {10'd5, -10'sd3, 10'd60};
        r.vy = {-10'sd4, 10'd3, 10'd2};
        r.vz = {16'h8000, 16'h7fff, 16'h0000};
        queued = queue_triangle(r, 3);
        r.vx = {10'd0, 10'd2, 10'd0};
        r.vy = {10'd2, 10'd0, 10'd0};
        r.vz = {16'h7fff, 16'h7fff, 16'h7fff};
        queued = queue_triangle(r, box_pixels(r));
        // same triangle again: the depth test must now reject it
        queued = queue_triangle(r, box_pixels(r));
        pending_reqs.push_back(plain_req(REQ_CLEAR));
        queued = queue_triangle(r, box_pixels(r) + 1);
        // zero area: point triangle
        r.vx = {10'd40, 10'd40, 10'd40};
        r.vy = {10'd63, 10'd63, 10'd63};
        queued = queue_triangle(r, 2);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        shades = '{8'd0, 8'd255, 8'h5a};
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 61 : 0;
            rx_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 8 : 0;
            write_shade((phase == 2) ? 8'($urandom) : shades[phase]);
            phase_goal = 550;
            queued = 0;
            while (queued < phase_goal)
            begin
                int pick;
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    queued += random_triangle();
                else if (pick < 83)
                begin
                    pending_reqs.push_back(plain_req(REQ_CLEAR));
                    queued++;
                end
                else if (pick < 93)
                begin
                    pending_reqs.push_back(plain_req(REQ_SCAN));
                    queued++;
                end
                else
                    pending_reqs.push_back(plain_req(2'd3));
                // hold off the sender until everything has drained once a phase
                if (queued >= phase_goal / 2 && queued < phase_goal / 2 + 40)
                begin
                    wait_drained();
                    queued += 40;
                end
            end
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        $display("Covered %0d loads, %0d clears, %0d scan results, %0d fragments drawn",
                 n_loads, n_clears, n_results, n_frags);
        $display("Shade values 0, 255 and a random level, with both sides stalling");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/tdr_pkg.sv
sv/tdr_divider.sv
sv/triangle_depth_rasterizer_top.sv
sim/tb_triangle_depth_rasterizer_top.sv
